// ===== hw/rtl/bce_pkg.sv =====
// Shared types and constants for the bitmap cell glyph encoder.
// Depends on nothing; imported by every module of the block.
package bce_pkg;

    // Screen memory layout
    localparam int MEM_BYTES    = 6912;
    localparam int BITMAP_BYTES = 6144;
    localparam int ATTR_ROWS    = 24;
    localparam int BITMAP_LINES = 192;
    localparam int ADDR_W       = 13;

    // Output code bases
    localparam logic [6:0] FG_BASE        = 7'd30;
    localparam logic [6:0] BRIGHT_OFFSET  = 7'd60;
    localparam logic [5:0] BG_BASE        = 6'd40;
    localparam logic [7:0] UTF8_SECOND_BASE = 8'hA0;
    localparam logic [7:0] UTF8_THIRD_BASE  = 8'h80;

    // Item commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    // Render modes
    localparam logic MODE_BLOCK   = 1'b0;
    localparam logic MODE_BRAILLE = 1'b1;

    // Fetched cell data handed from the sequencer to the formatter.
    // pix holds two pixels per row: {row3 L,R, row2 L,R, row1 L,R, row0 L,R}.
    typedef struct packed {
        logic       mode;
        logic       first_col;
        logic [7:0] pix;
        logic [6:0] attr;
    } cell_t;

    // Terminal colour order for the 3-bit palette index
    function automatic logic [2:0] colour_map(input logic [2:0] c);
        logic [2:0] m;
        case (c)
            3'd0:    m = 3'd0;
            3'd1:    m = 3'd4;
            3'd2:    m = 3'd1;
            3'd3:    m = 3'd5;
            3'd4:    m = 3'd2;
            3'd5:    m = 3'd6;
            3'd6:    m = 3'd3;
            default: m = 3'd7;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/bce_screen_ram.sv =====
// Single-port 6912 x 8 screen memory with registered read data.
// Depends on bce_pkg for depth and address width.
module bce_screen_ram
    import bce_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [MEM_BYTES];
    logic [7:0] rdata_reg;

    // One access per cycle: write or read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bce_cell_ctrl.sv =====
// Sequencer: accepts items, writes the screen memory, fetches the attribute
// and pixel row bytes of a cell and hands the gathered cell on.
// Depends on bce_pkg.
module bce_cell_ctrl
    import bce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // config
    input  logic              cfg_valid,
    input  logic              cfg_data,
    // item channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [ADDR_W-1:0] mem_address,
    input  logic [7:0]        mem_data,
    input  logic [6:0]        cell_x,
    input  logic [6:0]        cell_y,
    // memory port
    output logic              ram_we,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_addr,
    output logic [7:0]        ram_wdata,
    input  logic [7:0]        ram_rdata,
    // to formatter
    output logic              cell_valid,
    input  logic              cell_ready,
    output cell_t             cell_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_LAST  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Step 0 reads the attribute byte; steps 1..4 read pixel rows.
    // Returns {row below bitmap, address}.
    function automatic logic [ADDR_W:0] step_addr(
        input logic [6:0] cx,
        input logic [6:0] cy,
        input logic       mode,
        input logic [2:0] step
    );
        logic [8:0] py;
        logic [8:0] y;
        logic [5:0] arow;
        logic [2:0] step_m1;
        logic [ADDR_W:0] res;
        py = (mode == MODE_BRAILLE) ? {cy, 2'b00} : {1'b0, cy, 1'b0};
        // attribute row modulo 24; the row reaches 63 at most
        arow = py[8:3];
        if (arow >= 6'(2 * ATTR_ROWS))
        begin
            arow = arow - 6'(2 * ATTR_ROWS);
        end
        else if (arow >= 6'(ATTR_ROWS))
        begin
            arow = arow - 6'(ATTR_ROWS);
        end
        step_m1 = step - 3'd1;
        y = py + {6'd0, step_m1};
        if (step == 3'd0)
        begin
            res = {1'b0, ADDR_W'(BITMAP_BYTES) + {3'b000, arow[4:0], cx[6:2]}};
        end
        else
        begin
            res = {(y >= 9'(BITMAP_LINES)), y[7:6], y[2:0], y[5:3], cx[6:2]};
        end
        return res;
    endfunction

    logic [1:0]        state_reg, state_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [6:0]        cx_reg, cx_next;
    logic [6:0]        cy_reg, cy_next;
    logic              mode_reg, mode_next;
    logic              glyph_mode_reg;
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_zero_reg, rd_zero_next;
    logic [2:0]        rd_step_reg, rd_step_next;
    logic [6:0]        attr_reg;
    logic [7:0]        pix_reg;

    logic              accept;
    logic [ADDR_W:0]   sa;
    logic [2:0]        last_step;
    logic [7:0]        cap_byte;
    logic [7:0]        cap_shift;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_mode_reg <= MODE_BRAILLE;
        end
        else if (cfg_valid)
        begin
            glyph_mode_reg <= cfg_data;
        end
    end

    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && cell_ready);
    assign accept   = in_valid && in_ready;
    assign last_step = (mode_reg == MODE_BRAILLE) ? 3'd4 : 3'd2;

    // Address generation: attribute read starts in the accept cycle
    always_comb
    begin
        if (accept)
        begin
            sa = step_addr(cell_x, cell_y, glyph_mode_reg, 3'd0);
        end
        else
        begin
            sa = step_addr(cx_reg, cy_reg, mode_reg, cnt_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        mode_next    = mode_reg;
        rd_pend_next = 1'b0;
        rd_zero_next = 1'b0;
        rd_step_next = rd_step_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_addr     = sa[ADDR_W-1:0];
        ram_wdata    = mem_data;
        case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                if ((state_reg == ST_DONE) && cell_ready)
                begin
                    state_next = ST_IDLE;
                end
                if (accept)
                begin
                    if (cmd == CMD_WRITE)
                    begin
                        ram_addr = mem_address;
                        ram_we   = (mem_address < ADDR_W'(MEM_BYTES));
                    end
                    else
                    begin
                        ram_re       = 1'b1;
                        rd_pend_next = 1'b1;
                        rd_step_next = 3'd0;
                        cx_next      = cell_x;
                        cy_next      = cell_y;
                        mode_next    = glyph_mode_reg;
                        cnt_next     = 3'd1;
                        state_next   = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                ram_re       = !sa[ADDR_W];
                rd_pend_next = 1'b1;
                rd_zero_next = sa[ADDR_W];
                rd_step_next = cnt_reg;
                if (cnt_reg == last_step)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 3'd0;
            rd_pend_reg <= 1'b0;
            rd_zero_reg <= 1'b0;
            rd_step_reg <= 3'd0;
            mode_reg    <= MODE_BRAILLE;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_pend_next;
            rd_zero_reg <= rd_zero_next;
            rd_step_reg <= rd_step_next;
            mode_reg    <= mode_next;
        end
    end

    // Capture returning bytes; keep only the two pixels of this cell per row
    assign cap_byte  = rd_zero_reg ? 8'd0 : ram_rdata;
    assign cap_shift = cap_byte << {cx_reg[1:0], 1'b0};

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        if (rd_pend_reg)
        begin
            case (rd_step_reg)
                3'd0:    attr_reg     <= cap_byte[6:0];
                3'd1:    pix_reg[1:0] <= cap_shift[7:6];
                3'd2:    pix_reg[3:2] <= cap_shift[7:6];
                3'd3:    pix_reg[5:4] <= cap_shift[7:6];
                default: pix_reg[7:6] <= cap_shift[7:6];
            endcase
        end
    end

    assign cell_valid          = (state_reg == ST_DONE);
    assign cell_data.mode      = mode_reg;
    assign cell_data.first_col = (cx_reg == 7'd0);
    assign cell_data.pix       = pix_reg;
    assign cell_data.attr      = attr_reg;

endmodule

// ===== hw/rtl/bce_glyph_fmt.sv =====
// Formatter: packs the glyph pattern, decodes colours, tracks colour
// changes and holds the result beat in the output register.
// Depends on bce_pkg.
module bce_glyph_fmt
    import bce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cell_valid,
    output logic       cell_ready,
    input  cell_t      cell_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] pattern,
    output logic [2:0] ink,
    output logic [2:0] paper,
    output logic       bright,
    output logic       color_change,
    output logic [6:0] fg_code,
    output logic [5:0] bg_code,
    output logic [7:0] utf8_second,
    output logic [7:0] utf8_third
);

    logic       out_valid_reg, out_valid_next;
    logic [6:0] last_color_reg;
    logic [7:0] pattern_reg;
    logic [2:0] ink_reg, paper_reg;
    logic       bright_reg, change_reg;
    logic [6:0] fg_reg;
    logic [5:0] bg_reg;
    logic [7:0] u2_reg, u3_reg;

    logic       take;
    logic [7:0] pat;
    logic [6:0] fg;
    logic [5:0] bg;

    assign cell_ready = !out_valid_reg || out_ready;
    assign take       = cell_valid && cell_ready;

    // Glyph packing; pix row r is {L,R} at bits [2r+1:2r]
    always_comb
    begin
        if (cell_data.mode == MODE_BRAILLE)
        begin
            pat = {cell_data.pix[6], cell_data.pix[7], cell_data.pix[4], cell_data.pix[2],
                   cell_data.pix[0], cell_data.pix[5], cell_data.pix[3], cell_data.pix[1]};
        end
        else
        begin
            pat = {4'd0, cell_data.pix[1], cell_data.pix[0],
                   cell_data.pix[3], cell_data.pix[2]};
        end
    end

    // ANSI colour codes
    assign fg = FG_BASE + {4'd0, colour_map(cell_data.attr[2:0])}
              + (cell_data.attr[6] ? BRIGHT_OFFSET : 7'd0);
    assign bg = BG_BASE + {3'd0, colour_map(cell_data.attr[5:3])};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            last_color_reg <= 7'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                last_color_reg <= cell_data.attr;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pattern_reg <= pat;
            ink_reg     <= cell_data.attr[2:0];
            paper_reg   <= cell_data.attr[5:3];
            bright_reg  <= cell_data.attr[6];
            change_reg  <= cell_data.first_col || (cell_data.attr != last_color_reg);
            fg_reg      <= fg;
            bg_reg      <= bg;
            u2_reg      <= (cell_data.mode == MODE_BRAILLE)
                           ? UTF8_SECOND_BASE + {6'd0, pat[7:6]} : 8'd0;
            u3_reg      <= (cell_data.mode == MODE_BRAILLE)
                           ? UTF8_THIRD_BASE + {2'd0, pat[5:0]} : 8'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pattern      = pattern_reg;
    assign ink          = ink_reg;
    assign paper        = paper_reg;
    assign bright       = bright_reg;
    assign color_change = change_reg;
    assign fg_code      = fg_reg;
    assign bg_code      = bg_reg;
    assign utf8_second  = u2_reg;
    assign utf8_third   = u3_reg;

endmodule

// ===== hw/rtl/bitmap_cell_glyph_encoder.sv =====
// Top level of the bitmap cell glyph encoder: sequencer, screen memory, formatter.
// Depends on bce_pkg, bce_screen_ram, bce_cell_ctrl, bce_glyph_fmt.
//
//   channel   handshake               beat contents
//   cfg       cfg_valid / cfg_ready   cfg_data = glyph mode (0 block, 1 braille)
//   in        in_valid / in_ready     cmd, mem_address, mem_data, cell_x, cell_y
//   out       out_valid / out_ready   pattern, ink, paper, bright, color_change,
//                                     fg_code, bg_code, utf8_second, utf8_third
//
// A write beat is written to memory in the cycle it is accepted. A render
// beat reads the single-port screen memory one access per cycle (attribute
// byte, then 2 pixel rows in block mode or 4 in braille mode), then waits for
// the data return and hands the cell off. The result is held in an output
// register while the next beat is taken; a full one stalls the sequencer.
// Reset clears control state and sets braille mode; memory contents are kept.
module bitmap_cell_glyph_encoder
    import bce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [ADDR_W-1:0] mem_address,
    input  logic [7:0]        mem_data,
    input  logic [6:0]        cell_x,
    input  logic [6:0]        cell_y,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        pattern,
    output logic [2:0]        ink,
    output logic [2:0]        paper,
    output logic              bright,
    output logic              color_change,
    output logic [6:0]        fg_code,
    output logic [5:0]        bg_code,
    output logic [7:0]        utf8_second,
    output logic [7:0]        utf8_third
);

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic              cell_valid, cell_ready;
    cell_t             cell_data;

    // Register write always completes
    assign cfg_ready = 1'b1;

    bce_cell_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .mem_address (mem_address),
        .mem_data    (mem_data),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .ram_we      (ram_we),
        .ram_re      (ram_re),
        .ram_addr    (ram_addr),
        .ram_wdata   (ram_wdata),
        .ram_rdata   (ram_rdata),
        .cell_valid  (cell_valid),
        .cell_ready  (cell_ready),
        .cell_data   (cell_data)
    );

    bce_screen_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bce_glyph_fmt u_fmt (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_ready   (cell_ready),
        .cell_data    (cell_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pattern      (pattern),
        .ink          (ink),
        .paper        (paper),
        .bright       (bright),
        .color_change (color_change),
        .fg_code      (fg_code),
        .bg_code      (bg_code),
        .utf8_second  (utf8_second),
        .utf8_third   (utf8_third)
    );

endmodule
